// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: label");

`endif

// File: design/hhnc_pkg.sv
// ----------------------------------------------------------------------------
// hhnc_pkg
// Types, the header name table and lookup functions for the classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hhnc_pkg;

   localparam int NAME_COUNT = 47;
   localparam int NAME_SLOT  = 20;
   localparam int KIND_WIDTH = 6;
   localparam int POS_WIDTH  = 5;

   // Result code for a name that is not in the table.
   localparam logic [KIND_WIDTH-1:0] EXT_KIND = 6'd47;
   // Byte position saturates here.
   localparam logic [POS_WIDTH-1:0]  POS_MAX  = 5'd31;

   typedef logic [NAME_COUNT-1:0]  name_mask_type;
   typedef logic [NAME_SLOT*8-1:0] name_text_type;

   // Outcome of one byte step: surviving candidates and the resolved kind.
   typedef struct packed {
      name_mask_type         alive;
      logic [KIND_WIDTH-1:0] kind;
   } step_result_type;

   // Lower-case header names; each string is right-justified in its slot.
   localparam name_text_type NAME_TABLE [NAME_COUNT] = '{
      "cache-control", "connection", "date", "pragma", "trailer",
      "transfer-encoding", "upgrade", "via", "warning",
      "accept", "accept-charset", "accept-encoding", "accept-language",
      "authorization", "expect", "from", "host", "if-match",
      "if-modified-since", "if-none-match", "if-range",
      "if-unmodified-since", "max-forwards", "proxy-authorization",
      "range", "referer", "te", "user-agent",
      "accept-ranges", "age", "etag", "location", "proxy-authenticate",
      "retry-after", "server", "vary", "www-authenticate",
      "allow", "content-encoding", "content-language", "content-length",
      "content-location", "content-md5", "content-range", "content-type",
      "expires", "last-modified"
   };

   // Number of characters in table entry idx.
   function automatic logic [POS_WIDTH-1:0] name_len(input int idx);
      int n;
      n = 0;
      for (int k = 0; k < NAME_SLOT; k++) begin
         if (NAME_TABLE[idx][k*8 +: 8] != 8'h00) begin
            n++;
         end
      end
      return POS_WIDTH'(n);
   endfunction

   // Character at position pos of entry idx, zero beyond the end.
   function automatic logic [7:0] name_char(input int idx, input logic [POS_WIDTH-1:0] pos);
      logic [7:0] ch;
      int         len;
      ch  = 8'h00;
      len = int'(name_len(idx));
      for (int k = 0; k < NAME_SLOT; k++) begin
         if ((POS_WIDTH'(k) == pos) && (k < len)) begin
            ch = NAME_TABLE[idx][(len-1-k)*8 +: 8];
         end
      end
      return ch;
   endfunction

   // Fold ASCII upper-case letters to lower case; other bytes pass.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if ((c >= 8'h41) && (c <= 8'h5A)) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// File: design/hhnc_resolve.sv
// ----------------------------------------------------------------------------
// hhnc_resolve
// Picks the first surviving candidate whose length ends at this byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhnc_resolve (
   input  hhnc_pkg::name_mask_type                alive,
   input  logic [hhnc_pkg::POS_WIDTH-1:0]         pos,
   output logic [hhnc_pkg::KIND_WIDTH-1:0]        kind
);

   hhnc_pkg::name_mask_type          exact;
   logic [hhnc_pkg::POS_WIDTH:0]     pos_next;

   assign pos_next = {1'b0, pos} + {{hhnc_pkg::POS_WIDTH{1'b0}}, 1'b1};

   // A candidate matches exactly when its length equals the bytes seen.
   always_comb begin
      for (int i = 0; i < hhnc_pkg::NAME_COUNT; i++) begin
         exact[i] = alive[i] && ({1'b0, hhnc_pkg::name_len(i)} == pos_next);
      end
   end

   // Priority encode, lowest table index wins.
   always_comb begin
      kind = hhnc_pkg::EXT_KIND;
      for (int i = hhnc_pkg::NAME_COUNT - 1; i >= 0; i--) begin
         if (exact[i]) begin
            kind = hhnc_pkg::KIND_WIDTH'(i);
         end
      end
   end

endmodule

// File: design/hhnc_match.sv
// ----------------------------------------------------------------------------
// hhnc_match
// Compares one folded byte against every table entry at the current position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhnc_match (
   input  logic [7:0]                      name_byte,
   input  logic [hhnc_pkg::POS_WIDTH-1:0]  pos,
   input  hhnc_pkg::name_mask_type         alive,
   output hhnc_pkg::step_result_type       result
);

   logic [7:0]              folded;
   hhnc_pkg::name_mask_type alive_next;
   logic [hhnc_pkg::KIND_WIDTH-1:0] kind;

   assign folded = hhnc_pkg::fold_case(name_byte);

   // A candidate survives if it was alive, is long enough and the byte agrees.
   always_comb begin
      for (int i = 0; i < hhnc_pkg::NAME_COUNT; i++) begin
         alive_next[i] = alive[i]
                      && (pos < hhnc_pkg::name_len(i))
                      && (hhnc_pkg::name_char(i, pos) == folded);
      end
   end

   hhnc_resolve u_resolve (
      .alive (alive_next),
      .pos   (pos),
      .kind  (kind)
   );

   assign result.alive = alive_next;
   assign result.kind  = kind;

endmodule

// File: design/http_header_name_classifier_top.sv
// ----------------------------------------------------------------------------
// http_header_name_classifier_top
// Case-insensitive classifier of HTTP/1.1 header names, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one name byte per cycle while its output is not stalled and
// gives one result per name, on the transfer that carries the final-byte flag:
// the table index 0..46 of the first exact match, or 47 for an extension
// header. The final byte passes through the input register and the compare,
// and the result is registered; it is held while the output stalls. The
// sustained rate is one byte per cycle, set by the registered update of the
// candidate mask and byte position, which feeds back into the next byte's
// compare. An input register in front of the match logic lets one more byte
// be taken while a result waits on a stalled output.
`timescale 1ns / 1ps

module http_header_name_classifier_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_name_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_header_kind
);

   logic                             in_valid_ff, in_valid_in;
   logic [7:0]                       in_byte_ff, in_byte_in;
   logic                             in_final_ff, in_final_in;
   hhnc_pkg::name_mask_type          mask_ff, mask_in;
   logic [hhnc_pkg::POS_WIDTH-1:0]   pos_ff, pos_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [hhnc_pkg::KIND_WIDTH-1:0]  rsp_kind_ff, rsp_kind_in;
   logic                             advance;
   logic                             step;
   hhnc_pkg::step_result_type        result;

   // The compare stage moves unless a result is held by a stalled receiver.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign step      = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;

   // Input register loads whenever it is free or drains this cycle.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_name_byte;
         in_final_in = req_final_byte;
      end
   end

   hhnc_match u_match (
      .name_byte (in_byte_ff),
      .pos       (pos_ff),
      .alive     (mask_ff),
      .result    (result)
   );

   // Candidate state advances per byte and clears after the final byte.
   always_comb begin
      mask_in = mask_ff;
      pos_in  = pos_ff;
      if (step) begin
         if (in_final_ff) begin
            mask_in = '1;
            pos_in  = '0;
         end else begin
            mask_in = result.alive;
            if (pos_ff != hhnc_pkg::POS_MAX) begin
               pos_in = pos_ff + hhnc_pkg::POS_WIDTH'(1);
            end
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff && in_final_ff;
         if (step && in_final_ff) begin
            rsp_kind_in = result.kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mask_ff      <= '1;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_header_kind = rsp_kind_ff;

endmodule

// File: design/hhnc_checker.sv
// ----------------------------------------------------------------------------
// hhnc_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hhnc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_name_byte,
   input logic       req_final_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_header_kind
);

   // The input side only stalls while a result is held by the receiver.
   `ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A delivered kind is a table index or the extension code.
   `ASSERT_IMPLY(a_kind_range, clock, reset, rsp_valid, rsp_header_kind <= 6'd47)

   // A stalled result transfer stays valid.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result keeps its kind.
   `ASSERT_NEXT(a_kind_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_header_kind))

   // A stalled input transfer stays offered with the same byte and flag.
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_name_byte) && $stable(req_final_byte))

endmodule

bind http_header_name_classifier_top hhnc_checker u_hhnc_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the HTTP header name classifier.
// ----------------------------------------------------------------------------
// Header names are sent one byte per transfer, with the final-byte flag on
// the last byte. A behavioral classifier in the bench folds case, narrows
// its own candidate mask byte by byte and works out the expected header
// kind for each name. Each result transfer is compared against the oldest
// expected kind. The test sequence covers directed single bytes, known
// names in mixed case, the edges of case folding, and names past the
// saturating byte position. Random traffic follows, and both sides idle at
// random.
`timescale 1ns / 1ps

module tb_top;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_BYTES = 1100;
   localparam int DRAIN_CYCLES = 8;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_name_byte  = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [5:0] rsp_header_kind;

   // Known header names in classification order, lower case.
   string known_names [hhnc_pkg::NAME_COUNT] = '{
      "cache-control", "connection", "date", "pragma", "trailer",
      "transfer-encoding", "upgrade", "via", "warning",
      "accept", "accept-charset", "accept-encoding", "accept-language",
      "authorization", "expect", "from", "host", "if-match",
      "if-modified-since", "if-none-match", "if-range",
      "if-unmodified-since", "max-forwards", "proxy-authorization",
      "range", "referer", "te", "user-agent",
      "accept-ranges", "age", "etag", "location", "proxy-authenticate",
      "retry-after", "server", "vary", "www-authenticate",
      "allow", "content-encoding", "content-language", "content-length",
      "content-location", "content-md5", "content-range", "content-type",
      "expires", "last-modified"
   };

   // Classifier state mirrored in the bench.
   logic [hhnc_pkg::NAME_COUNT-1:0] candidates = '1;
   logic [4:0]                      byte_pos   = '0;

   logic [5:0] expected_kinds [$];
   logic [7:0] name_buf [$];
   logic [5:0] want_kind;

   int  fail_count  = 0;
   int  bytes_sent  = 0;
   int  idle_cycles = 0;
   int  stall_hold  = 0;
   bit  quiet       = 1'b0;

   http_header_name_classifier_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_name_byte   (req_name_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_kind (rsp_header_kind)
   );

   // Clock generation.
   initial begin
      forever #2 clock = ~clock;
   end

   // Record one failure; only the first few are printed in detail.
   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Advance the mirrored classifier by one byte and queue the kind it
   // yields when the byte closes the name.
   task automatic classify_byte(input logic [7:0] b, input logic fin);
      logic [7:0]                      folded;
      logic [hhnc_pkg::NAME_COUNT-1:0] survivors;
      logic [5:0]                      kind;
      folded    = ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'h20 : b;
      survivors = '0;
      for (int i = 0; i < hhnc_pkg::NAME_COUNT; i++) begin
         if (candidates[i] && (int'(byte_pos) < known_names[i].len()) &&
             (8'(known_names[i][byte_pos]) == folded)) begin
            survivors[i] = 1'b1;
         end
      end
      candidates = survivors;
      if (!fin) begin
         if (byte_pos < hhnc_pkg::POS_MAX) begin
            byte_pos = byte_pos + 5'd1;
         end
      end else begin
         kind = hhnc_pkg::EXT_KIND;
         for (int i = hhnc_pkg::NAME_COUNT - 1; i >= 0; i--) begin
            if (candidates[i] && (known_names[i].len() == int'(byte_pos) + 1)) begin
               kind = 6'(i);
            end
         end
         expected_kinds.push_back(kind);
         candidates = '1;
         byte_pos   = '0;
      end
   endtask

   // Sender gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || (r < 55)) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(30, 10);
   endfunction

   // Offer one byte, hold it until it is taken, then maybe idle.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      req_valid      <= 1'b1;
      req_name_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      classify_byte(b, fin);
      bytes_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Send the buffered name; the last byte carries the final flag.
   task automatic send_name_buf();
      for (int k = 0; k < name_buf.size(); k++) begin
         send_byte(name_buf[k], k == name_buf.size() - 1);
      end
   endtask

   task automatic send_text(input string s);
      name_buf.delete();
      for (int k = 0; k < s.len(); k++) begin
         name_buf.push_back(8'(s[k]));
      end
      send_name_buf();
   endtask

   // Hold the input idle until every expected result has arrived.
   task automatic wait_drained();
      if (expected_kinds.size() != 0) begin
         req_valid <= 1'b0;
         while (expected_kinds.size() != 0) begin
            @(posedge clock);
         end
      end
   endtask

   // One-byte names: the byte extremes and the bytes just outside A-Z and a-z.
   task automatic test_single_bytes();
      quiet = 1'b1;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h40, 1'b1);
      send_byte(8'h5B, 1'b1);
      send_byte(8'h60, 1'b1);
      send_byte(8'h7B, 1'b1);
   endtask

   // Known names in mixed case, a name with a wrong last byte, a bare prefix and a name one byte too long.
   task automatic test_known_names();
      quiet = 1'b0;
      send_text("TE");
      send_text("vIa");
      send_text("AGE");
      send_text("dAtZ");
      send_text("t");
      send_text("ager");
      wait_drained();
   endtask

   // Names past the last byte position; the position saturates.
   task automatic test_long_names();
      send_text("Content-Length-and-a-lot-more-text-xyz");
      name_buf.delete();
      repeat (36) name_buf.push_back(8'h61);
      send_name_buf();
   endtask

   // Build one random name: mostly table names with random case and
   // an occasional flaw, otherwise short or long random byte strings.
   task automatic build_random_name();
      int         r;
      int         idx;
      int         len;
      logic [7:0] ch;
      name_buf.delete();
      r = $urandom_range(99);
      if (r < 72) begin
         idx = $urandom_range(hhnc_pkg::NAME_COUNT - 1);
         for (int k = 0; k < known_names[idx].len(); k++) begin
            ch = 8'(known_names[idx][k]);
            if ((ch >= 8'h61) && (ch <= 8'h7A) && ($urandom_range(1) == 1)) begin
               ch = ch - 8'h20;
            end
            name_buf.push_back(ch);
         end
         r = $urandom_range(99);
         if (r < 12) begin
            len = $urandom_range(name_buf.size(), 1);
            while (name_buf.size() > len) void'(name_buf.pop_back());
         end else if (r < 22) begin
            repeat ($urandom_range(6, 1)) name_buf.push_back(8'($urandom_range(255)));
         end else if (r < 32) begin
            name_buf[$urandom_range(name_buf.size() - 1)] = 8'($urandom_range(255));
         end else if (r < 36) begin
            while (name_buf.size() < 33) name_buf.push_back(8'h2D);
         end
      end else if (r < 92) begin
         repeat ($urandom_range(6, 1)) begin
            if ($urandom_range(1) == 1) begin
               name_buf.push_back(8'($urandom_range(255)));
            end else begin
               name_buf.push_back(8'($urandom_range(8'h7A, 8'h41)));
            end
         end
      end else begin
         repeat ($urandom_range(40, 20)) name_buf.push_back(8'($urandom_range(255)));
      end
   endtask

   // Random traffic in phases, some without idling, with drains between some phases.
   task automatic test_random_traffic();
      int target;
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         quiet = ($urandom_range(3) == 0);
         repeat ($urandom_range(20, 5)) begin
            build_random_name();
            send_name_buf();
         end
         if ($urandom_range(2) == 0) begin
            wait_drained();
         end
      end
      quiet = 1'b0;
   endtask

   // Receiver stall: runs of open and stalled cycles of random length.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               rsp_stall  <= 1'b0;
               stall_hold <= $urandom_range(8, 0);
            end
            6, 7, 8: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(2, 0);
            end
            default: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(40, 10);
            end
         endcase
      end
   end

   // Result check against the oldest expected kind.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_kinds.size() == 0) begin
            note_failure($sformatf("unexpected result transfer, kind %0d",
                                   rsp_header_kind));
         end else begin
            want_kind = expected_kinds.pop_front();
            if (rsp_header_kind !== want_kind) begin
               note_failure($sformatf("header_kind mismatch: expected %0d, got %0d",
                                      want_kind, rsp_header_kind));
            end
         end
      end
   end

   // Watchdog on cycles in which no transfer happens on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_single_bytes();
      test_known_names();
      test_long_names();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_kinds.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", expected_kinds.size()));
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
